FILE: rtl/rnge_pkg.sv
// shared types and constants of the radix-n group encoder
package rnge_pkg;

  localparam int MAX_BYTES   = 7;
  localparam int BUF_W       = 8 * MAX_BYTES;
  localparam int MAX_SYMBOLS = 56;

  // character kinds on the output
  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_PAD    = 2'd1;
  localparam logic [1:0] KIND_CR     = 2'd2;
  localparam logic [1:0] KIND_LF     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GROUP_BYTES  = 3'd0;
  localparam logic [2:0] REG_SYMBOL_BITS  = 3'd1;
  localparam logic [2:0] REG_SYMBOL_MASK  = 3'd2;
  localparam logic [2:0] REG_SYMS_PER_GRP = 3'd3;
  localparam logic [2:0] REG_LINE_BREAK   = 3'd4;
  localparam logic [2:0] REG_PADDING      = 3'd5;

  // effective configuration, zero widths and oversize counts already fixed up
  typedef struct packed {
    logic [2:0] group_bytes;
    logic [2:0] symbol_bits;
    logic [6:0] symbol_mask;
    logic [5:0] symbols_per_group;
    logic       line_break_enable;
    logic       padding_enable;
  } cfg_t;

  // one group handed from the front to the back
  typedef struct packed {
    logic [BUF_W-1:0] data;     // bytes in the low 8*count bits, oldest highest
    logic [2:0]       count;
    logic             last;
    logic             partial;  // ends the message without filling the group
  } job_t;

endpackage

FILE: rtl/rnge_front.sv
// front end: collects message bytes into groups and posts them to the job queue
module rnge_front (
  input  logic            clk,
  input  logic            rst,
  input  rnge_pkg::cfg_t  cfg,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  input  logic            byte_fire,
  output logic            push,
  output rnge_pkg::job_t  push_job
);
  import rnge_pkg::*;

  logic [BUF_W-1:0] group_buffer;
  logic [2:0]       bytes_held;

  logic [2:0]       n;
  logic [BUF_W-1:0] v;
  logic             complete;

  assign n        = bytes_held + 3'd1;
  assign v        = {group_buffer[BUF_W-9:0], data_byte};
  assign complete = (n >= cfg.group_bytes);

  assign push             = byte_fire && (complete || last_byte);
  assign push_job.data    = v;
  assign push_job.count   = n;
  assign push_job.last    = last_byte;
  assign push_job.partial = !complete;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_buffer <= '0;
      bytes_held   <= '0;
    end else if (byte_fire) begin
      if (complete || last_byte) begin
        group_buffer <= '0;
        bytes_held   <= '0;
      end else begin
        group_buffer <= v;
        bytes_held   <= n;
      end
    end
  end

endmodule

FILE: rtl/rnge_queue.sv
// two-entry job queue between front and back
module rnge_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rnge_pkg::job_t  push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output rnge_pkg::job_t  head
);
  import rnge_pkg::*;

  localparam int DEPTH = 2;

  job_t       slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(DEPTH));
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: rtl/rnge_back.sv
// back end: cuts a group into symbols, adds pad marks and line breaks, one character a cycle unless stalled
module rnge_back #(
  parameter int LINE_LENGTH = 76
) (
  input  logic            clk,
  input  logic            rst,
  input  rnge_pkg::cfg_t  cfg,
  input  logic            job_valid,
  input  rnge_pkg::job_t  job,
  output logic            pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [6:0] symbol_index, [7] zero
  output logic            m_tlast,   // last_of_run
  output logic [2:0]      m_tuser    // [1:0] char_kind, [2] message_end
);
  import rnge_pkg::*;

  logic             active;
  logic [BUF_W-1:0] t_buf;
  logic [6:0]       bits;
  logic [5:0]       made;
  logic             job_last;
  logic             pad_ok;
  logic             brk_lf;
  logic [7:0]       line_count;
  logic [1:0]       out_kind;
  logic [6:0]       out_index;
  logic             out_last;
  logic             out_end;

  logic             active_next;
  logic [BUF_W-1:0] t_buf_next;
  logic [6:0]       bits_next;
  logic [5:0]       made_next;
  logic             job_last_next;
  logic             pad_ok_next;
  logic             brk_lf_next;
  logic [7:0]       line_count_next;
  logic             m_tvalid_next;
  logic [1:0]       out_kind_next;
  logic [6:0]       out_index_next;
  logic             out_last_next;
  logic             out_end_next;

  logic             slot_free;
  logic             sym_left;
  logic [6:0]       bits_after;
  logic [5:0]       made_inc;
  logic [BUF_W+7:0] shifted;
  logic [6:0]       sym_idx;
  logic             more;

  assign slot_free  = !m_tvalid || m_tready;
  assign sym_left   = (bits > 7'd8);
  assign bits_after = bits - {4'd0, cfg.symbol_bits};
  assign made_inc   = made + 6'd1;
  assign shifted    = {t_buf, 8'd0} >> bits_after;
  assign sym_idx    = shifted[6:0] & cfg.symbol_mask;
  // another character of this group follows the one sent now
  assign more       = (sym_left && (bits_after > 7'd8)) ||
                      (pad_ok && (made_inc < cfg.symbols_per_group));

  assign pop = !active && job_valid;

  always_comb begin
    active_next     = active;
    t_buf_next      = t_buf;
    bits_next       = bits;
    made_next       = made;
    job_last_next   = job_last;
    pad_ok_next     = pad_ok;
    brk_lf_next     = brk_lf;
    line_count_next = line_count;
    m_tvalid_next   = m_tvalid;
    out_kind_next   = out_kind;
    out_index_next  = out_index;
    out_last_next   = out_last;
    out_end_next    = out_end;

    if (active && slot_free) begin
      m_tvalid_next = 1'b1;
      out_last_next = 1'b0;
      out_end_next  = 1'b0;
      if (brk_lf) begin
        out_kind_next  = KIND_LF;
        out_index_next = '0;
        brk_lf_next    = 1'b0;
      end else if (cfg.line_break_enable && (line_count >= 8'(LINE_LENGTH))) begin
        out_kind_next   = KIND_CR;
        out_index_next  = '0;
        brk_lf_next     = 1'b1;
        line_count_next = '0;
      end else begin
        if (sym_left) begin
          out_kind_next  = KIND_SYMBOL;
          out_index_next = sym_idx;
          bits_next      = bits_after;
        end else begin
          out_kind_next  = KIND_PAD;
          out_index_next = '0;
        end
        made_next       = made_inc;
        line_count_next = (line_count == 8'hff) ? line_count : line_count + 8'd1;
        out_last_next   = !more;
        out_end_next    = !more && job_last;
        if (!more) begin
          active_next = 1'b0;
          if (job_last) begin
            line_count_next = '0;
          end
        end
      end
    end else if (slot_free) begin
      m_tvalid_next = 1'b0;
    end

    if (pop) begin
      active_next   = 1'b1;
      t_buf_next    = job.data;
      bits_next     = ({4'd0, job.count} + 7'd1) << 3;
      made_next     = '0;
      job_last_next = job.last;
      pad_ok_next   = job.partial && cfg.padding_enable;
      brk_lf_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      brk_lf     <= 1'b0;
      line_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      active     <= active_next;
      brk_lf     <= brk_lf_next;
      line_count <= line_count_next;
      m_tvalid   <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    t_buf     <= t_buf_next;
    bits      <= bits_next;
    made      <= made_next;
    job_last  <= job_last_next;
    pad_ok    <= pad_ok_next;
    out_kind  <= out_kind_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
    out_end   <= out_end_next;
  end

  assign m_tdata = {1'b0, out_index};
  assign m_tlast = out_last;
  assign m_tuser = {out_end, out_kind};

`ifndef SYNTHESIS
  a_cr_then_lf: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && (m_tuser[1:0] == KIND_CR)) |=>
      (m_tvalid && (m_tuser[1:0] == KIND_LF)))
    else $error("carriage return not followed by line feed");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> m_tlast)
    else $error("message end without run end");
  a_break_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((m_tuser[1:0] == KIND_CR) || (m_tuser[1:0] == KIND_LF))) |-> !m_tlast)
    else $error("line break closes a run");
`endif

endmodule

FILE: rtl/radix_n_group_encoder.sv
// top level of the radix-n group encoder: configuration registers, front, queue, back
//
// Usage:
//   Message bytes enter on the s_ stream, one byte per transfer, s_tlast on the
//   final byte of a message. Result characters leave on the m_ stream: tuser
//   gives the kind (symbol, pad, CR, LF) and the message end flag, tdata the
//   symbol index, tlast ends a group's characters. The user must write the cfg_
//   port one register per cycle, only while the block is idle (not enforced).
// Timing:
//   The front takes one byte per cycle as long as the two-entry job queue has
//   room. The back loads a queued group and then sends one character per cycle
//   while the output is not stalled; it takes the next group only once the last
//   character of the current one is in the output register. A group's first
//   character passes the queue slot, the back's group registers and the output register.
// Reset:
//   rst clears the group buffer, the line counter and the queue, and loads the
//   base64 settings with padding and line breaks at LINE_LENGTH (76 by default).
// Stall:
//   While m_tready is low the output register holds; the back waits, the queue
//   fills, and then s_tready drops.
module radix_n_group_encoder #(
  parameter int LINE_LENGTH = 76
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] data_byte
  input  logic       s_tlast,     // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [6:0] symbol_index, [7] zero
  output logic       m_tlast,     // last_of_run
  output logic [2:0] m_tuser,     // [1:0] char_kind, [2] message_end
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_addr,
  input  logic [6:0] cfg_wr_data
);
  import rnge_pkg::*;

  logic [2:0] group_bytes;
  logic [2:0] symbol_bits;
  logic [6:0] symbol_mask;
  logic [5:0] symbols_per_group;
  logic       line_break_enable;
  logic       padding_enable;

  cfg_t cfg;
  job_t push_job;
  job_t head;
  logic push;
  logic pop;
  logic full;
  logic not_empty;
  logic byte_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes       <= 3'd3;
      symbol_bits       <= 3'd6;
      symbol_mask       <= 7'd63;
      symbols_per_group <= 6'd4;
      line_break_enable <= 1'b1;
      padding_enable    <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_GROUP_BYTES:  group_bytes       <= cfg_wr_data[2:0];
        REG_SYMBOL_BITS:  symbol_bits       <= cfg_wr_data[2:0];
        REG_SYMBOL_MASK:  symbol_mask       <= cfg_wr_data;
        REG_SYMS_PER_GRP: symbols_per_group <= cfg_wr_data[5:0];
        REG_LINE_BREAK:   line_break_enable <= cfg_wr_data[0];
        REG_PADDING:      padding_enable    <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  // zero sizes act as one, symbols per group top out at the widest group (MAX_SYMBOLS)
  assign cfg.group_bytes       = (group_bytes == 3'd0) ? 3'd1 : group_bytes;
  assign cfg.symbol_bits       = (symbol_bits == 3'd0) ? 3'd1 : symbol_bits;
  assign cfg.symbol_mask       = symbol_mask;
  assign cfg.symbols_per_group = (symbols_per_group > 6'(MAX_SYMBOLS)) ?
                                 6'(MAX_SYMBOLS) : symbols_per_group;
  assign cfg.line_break_enable = line_break_enable;
  assign cfg.padding_enable    = padding_enable;

  assign s_tready  = !full;
  assign byte_fire = s_tvalid && s_tready;

  rnge_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .byte_fire (byte_fire),
    .push      (push),
    .push_job  (push_job)
  );

  rnge_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  rnge_back #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (not_empty),
    .job       (head),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule
